[hdl/multiple_stacks_shared_memory_macros.svh]
// Assertion macros for the multiple-stacks block.
// Used by the top level only; expects clk and rst in scope.
`ifndef MULTIPLE_STACKS_SHARED_MEMORY_MACROS_SVH
`define MULTIPLE_STACKS_SHARED_MEMORY_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/msm_pkg.sv]
// Shared types and codes for the multiple-stacks block.
// No dependencies.
`default_nettype none

package msm_pkg;

  localparam int NUM_W = 4;
  localparam int IDX_W = 3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef struct packed {
    logic    pop_ok;
    status_t status;
  } res_t;

endpackage

`default_nettype wire

[hdl/multiple_stacks_shared_memory.sv]
// Top level: several stacks in one shared RAM, with result register.
// Depends on msm_pkg, msm_bounds, msm_ctrl, msm_ram and the macros header.
`default_nettype none
`include "multiple_stacks_shared_memory_macros.svh"

// One push or pop request is accepted per cycle; its result is valid the cycle
// after acceptance and a new request is taken while that result waits, as long
// as the output is not stalled. Pop data comes straight from the RAM's
// registered read port. A num_stacks write is taken at once, splits the RAM
// into slices, one per stack, and empties every stack in that cycle; there is
// no clearing pass, since an entry is only read after a push wrote it.
module multiple_stacks_shared_memory #(
  parameter int MEMORY_DEPTH = 256,
  parameter int STACK_LIMIT  = 8,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [3:0]             num_stacks,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic [2:0]             stack_index,
  input  logic [VALUE_WIDTH-1:0] push_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] pop_value,
  output logic [1:0]             status
);
  import msm_pkg::*;

  localparam int PW = $clog2(MEMORY_DEPTH + 1);
  localparam int AW = $clog2(MEMORY_DEPTH);

  logic                           cfg_we;
  logic                           acc;
  logic                           idx_bad;
  logic [NUM_W-1:0]               cnt;
  logic [STACK_LIMIT:0][PW-1:0]   bnd;
  logic [STACK_LIMIT:0][PW-1:0]   bnd_next;
  res_t                           res;
  res_t                           res_q;
  logic                           mem_we;
  logic                           mem_re;
  logic [AW-1:0]                  mem_addr;
  logic [VALUE_WIDTH-1:0]         rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = out_valid && out_stall;
  assign acc       = in_valid && !in_stall;
  assign idx_bad   = {1'b0, stack_index} >= cnt;

  msm_bounds #(
    .MEMORY_DEPTH(MEMORY_DEPTH),
    .STACK_LIMIT (STACK_LIMIT)
  ) u_bounds (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(num_stacks),
    .cnt     (cnt),
    .bnd     (bnd),
    .bnd_next(bnd_next)
  );

  msm_ctrl #(
    .MEMORY_DEPTH(MEMORY_DEPTH),
    .STACK_LIMIT (STACK_LIMIT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .acc        (acc),
    .operation  (operation),
    .stack_index(stack_index),
    .cnt        (cnt),
    .bnd        (bnd),
    .bnd_next   (bnd_next),
    .res        (res),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr)
  );

  msm_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MEMORY_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_addr),
    .wdata(push_value),
    .re   (mem_re),
    .raddr(mem_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign pop_value = res_q.pop_ok ? rdata : '0;
  assign status    = res_q.status;

  `MSM_ASSERT_NEXT(a_accept_gives_result, acc, out_valid, "accepted request produced no result")
  `MSM_ASSERT_NEXT(a_bad_index, acc && idx_bad, status == ST_BADIDX, "bad index not flagged")
  `MSM_ASSERT_NOW(a_error_zero, out_valid && status != ST_OK, pop_value == '0, "error result carries data")

endmodule

`default_nettype wire

[hdl/msm_ram.sv]
// Generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module msm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/msm_bounds.sv]
// Stack count register and slice boundary table.
// Depends on msm_pkg.
`default_nettype none

module msm_bounds #(
  parameter int MEMORY_DEPTH = 256,
  parameter int STACK_LIMIT  = 8
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_we,
  input  logic [msm_pkg::NUM_W-1:0]                       cfg_data,
  output logic [msm_pkg::NUM_W-1:0]                       cnt,
  output logic [STACK_LIMIT:0][$clog2(MEMORY_DEPTH+1)-1:0] bnd,
  output logic [STACK_LIMIT:0][$clog2(MEMORY_DEPTH+1)-1:0] bnd_next
);
  import msm_pkg::*;

  localparam int PW = $clog2(MEMORY_DEPTH + 1);
  localparam int MW = PW + 7;
  localparam int unsigned LimitEff = (STACK_LIMIT < 15) ? STACK_LIMIT : 15;
  localparam logic [NUM_W-1:0] LimitCnt = NUM_W'(LimitEff);
  localparam logic [PW-1:0] DepthP = PW'(MEMORY_DEPTH);

  logic [NUM_W-1:0]        cnt_next;
  logic [NUM_W-1:0]        clamped;
  logic [15:0][PW-1:0]     slice_tab;
  logic [PW-1:0]           slice;

  // slice size per count, worked out at elaboration
  for (genvar k = 0; k < 16; k++) begin : g_slice
    localparam int unsigned SliceK = MEMORY_DEPTH / ((k == 0) ? 1 : k);
    assign slice_tab[k] = PW'(SliceK);
  end

  always_comb begin
    clamped = cfg_data;
    if (cfg_data == '0) begin
      clamped = NUM_W'(1);
    end else if (cfg_data > LimitCnt) begin
      clamped = LimitCnt;
    end
    if (rst) begin
      cnt_next = NUM_W'(1);
    end else if (cfg_we) begin
      cnt_next = clamped;
    end else begin
      cnt_next = cnt;
    end
  end

  assign slice = slice_tab[cnt_next];
  assign bnd_next[0] = '0;

  for (genvar i = 1; i <= STACK_LIMIT; i++) begin : g_bnd
    logic [MW-1:0] prod;
    assign prod = MW'(slice) * MW'(i);
    assign bnd_next[i] = (7'(i) < {3'b000, cnt_next}) ? prod[PW-1:0] + PW'(1) : DepthP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= NUM_W'(1);
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    bnd <= bnd_next;
  end

endmodule

`default_nettype wire

[hdl/msm_ctrl.sv]
// Top pointers and per-request push/pop decision.
// Depends on msm_pkg; boundaries come from msm_bounds.
`default_nettype none

module msm_ctrl #(
  parameter int MEMORY_DEPTH = 256,
  parameter int STACK_LIMIT  = 8
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_we,
  input  logic                                            acc,
  input  logic                                            operation,
  input  logic [msm_pkg::IDX_W-1:0]                       stack_index,
  input  logic [msm_pkg::NUM_W-1:0]                       cnt,
  input  logic [STACK_LIMIT:0][$clog2(MEMORY_DEPTH+1)-1:0] bnd,
  input  logic [STACK_LIMIT:0][$clog2(MEMORY_DEPTH+1)-1:0] bnd_next,
  output msm_pkg::res_t                                   res,
  output logic                                            mem_we,
  output logic                                            mem_re,
  output logic [$clog2(MEMORY_DEPTH)-1:0]                 mem_addr
);
  import msm_pkg::*;

  localparam int PW  = $clog2(MEMORY_DEPTH + 1);
  localparam int AW  = $clog2(MEMORY_DEPTH);
  localparam int IW  = $clog2(STACK_LIMIT);
  localparam int BIW = $clog2(STACK_LIMIT + 1);
  localparam logic [PW-1:0] DepthP = PW'(MEMORY_DEPTH);

  logic [STACK_LIMIT-1:0][PW-1:0] tops;
  logic [6:0]    idx_x;
  logic [6:0]    idx_p1;
  logic [PW-1:0] t;
  logic [PW-1:0] t_inc;
  logic [PW-1:0] t_dec;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  logic [PW-1:0] t_upd;

  assign idx_x  = {4'b0000, stack_index};
  assign idx_p1 = idx_x + 7'd1;
  assign t      = tops[idx_x[IW-1:0]];
  assign lo     = bnd[idx_x[BIW-1:0]];
  assign hi     = bnd[idx_p1[BIW-1:0]];
  assign t_inc  = t + PW'(1);
  assign t_dec  = t - PW'(1);

  always_comb begin
    res.pop_ok = 1'b0;
    res.status = ST_OK;
    t_upd      = t;
    if ({1'b0, stack_index} >= cnt) begin
      res.status = ST_BADIDX;
    end else if (operation == OP_PUSH) begin
      if (t >= hi || t >= DepthP) begin
        res.status = ST_FULL;
      end else begin
        t_upd = t_inc;
      end
    end else begin
      if (t <= lo || t == '0 || t > DepthP) begin
        res.status = ST_EMPTY;
      end else begin
        res.pop_ok = 1'b1;
        t_upd      = t_dec;
      end
    end
  end

  assign mem_we   = acc && res.status == ST_OK && operation == OP_PUSH;
  assign mem_re   = acc && res.pop_ok;
  assign mem_addr = (operation == OP_PUSH) ? t[AW-1:0] : t_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < STACK_LIMIT; i++) begin
        tops[i] <= bnd_next[i];
      end
    end else if (acc && res.status == ST_OK) begin
      tops[idx_x[IW-1:0]] <= t_upd;
    end
  end

endmodule

`default_nettype wire
